### rtl/avdtp_signal_responder_core_defines.svh
// Assertion macros for the AVDTP signalling responder.
// Used by avdsr_emit, which checks its own control logic; no other dependencies.
`ifndef AVDTP_SIGNAL_RESPONDER_CORE_DEFINES_SVH
`define AVDTP_SIGNAL_RESPONDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AVDSR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AVDSR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AVDSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define AVDSR_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### rtl/avdsr_pkg.sv
// Shared types and constants for the AVDTP signalling responder.
// No dependencies; imported by every module of the block.
`default_nettype none

package avdsr_pkg;

    localparam logic [5:0] SIG_DISCOVER   = 6'h01;
    localparam logic [5:0] SIG_GET_CAPS   = 6'h02;
    localparam logic [5:0] SIG_SET_CONFIG = 6'h03;
    localparam logic [5:0] SIG_OPEN       = 6'h06;
    localparam logic [5:0] SIG_START      = 6'h07;
    localparam logic [5:0] SIG_CLOSE      = 6'h08;
    localparam logic [5:0] SIG_SUSPEND    = 6'h09;
    localparam logic [5:0] SIG_ABORT      = 6'h0A;

    localparam logic [1:0] MSG_CMD         = 2'd0;
    localparam logic [1:0] MSG_GEN_REJECT  = 2'd1;
    localparam logic [1:0] MSG_RSP_ACCEPT  = 2'd2;
    localparam logic [1:0] MSG_RSP_REJECT  = 2'd3;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_DISCOVER   = 3'd1;
    localparam logic [2:0] ST_CONFIGURED = 3'd2;
    localparam logic [2:0] ST_OPEN       = 3'd3;
    localparam logic [2:0] ST_STREAMING  = 3'd4;

    localparam logic [2:0] CFG_LOCAL_EP   = 3'd0;
    localparam logic [2:0] CFG_RATE_MODE  = 3'd1;
    localparam logic [2:0] CFG_BLOCK_SUB  = 3'd2;
    localparam logic [2:0] CFG_MIN_BPOOL  = 3'd3;
    localparam logic [2:0] CFG_MAX_BPOOL  = 3'd4;

    localparam logic [5:0] RST_LOCAL_EP  = 6'd1;
    localparam logic [7:0] RST_RATE_MODE = 8'h21;
    localparam logic [7:0] RST_BLOCK_SUB = 8'h83;
    localparam logic [7:0] RST_MIN_BPOOL = 8'd2;
    localparam logic [7:0] RST_MAX_BPOOL = 8'd53;

    localparam logic [3:0]  HDR_ACCEPT_LOW = 4'h2;
    localparam logic [15:0] MIN_LEN        = 16'd2;
    localparam logic [15:0] MIN_LEN_SETCFG = 16'd4;
    localparam logic [3:0]  LAST_DISCOVER  = 4'd3;
    localparam logic [3:0]  LAST_GET_CAPS  = 4'd11;
    localparam logic [3:0]  LAST_SHORT     = 4'd1;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  signal_byte;
        logic [7:0]  first_payload_byte;
        logic [15:0] packet_length;
    } t_req;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       reply_rejected;
        logic [2:0] stream_state;
        logic [5:0] remote_endpoint_id;
    } t_rsp;

    typedef struct packed {
        logic [5:0] local_endpoint_id;
        logic [7:0] codec_rate_mode_byte;
        logic [7:0] codec_block_subband_byte;
        logic [7:0] min_bitpool;
        logic [7:0] max_bitpool;
    } t_cfg;

    typedef struct packed {
        logic       notice;
        logic       rejected;
        logic [3:0] label;
        logic [5:0] sig;
        logic [3:0] last_idx;
        logic [2:0] stream_state;
        logic [5:0] remote_endpoint_id;
    } t_job;

endpackage

`default_nettype wire

### rtl/avdtp_signal_responder_core.sv
// AVDTP signalling responder. An accepted request goes to the job register, and its
// results go on to the result register, one result per cycle while the output is not
// stalled. A request holds the byte emitter until all its results (1, 2, 4 or 12) are
// out, and the next request is taken in the cycle its last result moves to the result
// register. Requests that give no result never load the emitter. Reset is synchronous,
// active low, and restores the configuration and stream state defaults.
`default_nettype none

module avdtp_signal_responder_core
    import avdsr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  t_req            i_in_req,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_rsp            o_out_rsp,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg cfg;
    t_job job;
    logic job_vld;
    logic full;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;
    assign accept      = i_in_valid && !full;

    avdsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    avdsr_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_req     (i_in_req),
        .o_job_vld (job_vld),
        .o_job     (job)
    );

    avdsr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (job_vld),
        .i_job       (job),
        .i_cfg       (cfg),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

### rtl/avdsr_cfg.sv
// Configuration register file of the AVDTP signalling responder.
// Depends on avdsr_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module avdsr_cfg
    import avdsr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr,
    input  wire logic [2:0] i_index,
    input  wire logic [7:0] i_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_LOCAL_EP:  n_cfg.local_endpoint_id        = i_data[5:0];
                CFG_RATE_MODE: n_cfg.codec_rate_mode_byte     = i_data;
                CFG_BLOCK_SUB: n_cfg.codec_block_subband_byte = i_data;
                CFG_MIN_BPOOL: n_cfg.min_bitpool              = i_data;
                CFG_MAX_BPOOL: n_cfg.max_bitpool              = i_data;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.local_endpoint_id        <= RST_LOCAL_EP;
            r_cfg.codec_rate_mode_byte     <= RST_RATE_MODE;
            r_cfg.codec_block_subband_byte <= RST_BLOCK_SUB;
            r_cfg.min_bitpool              <= RST_MIN_BPOOL;
            r_cfg.max_bitpool              <= RST_MAX_BPOOL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/avdsr_decode.sv
// Request decoder and stream state registers of the AVDTP signalling responder.
// Depends on avdsr_pkg; produces a reply job for the byte emitter.
`default_nettype none

module avdsr_decode
    import avdsr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  t_req      i_req,
    output logic      o_job_vld,
    output t_job      o_job
);

    logic [2:0] r_state;
    logic [5:0] r_remote;
    logic [2:0] n_state;
    logic [5:0] n_remote;
    logic       n_vld;
    logic [1:0] msg;
    logic [5:0] sig;
    logic       long_enough;

    assign msg         = i_req.header_byte[1:0];
    assign sig         = i_req.signal_byte[5:0];
    assign long_enough = i_req.packet_length >= MIN_LEN;

    always_comb begin
        n_state  = r_state;
        n_remote = r_remote;
        n_vld    = 1'b0;
        o_job.notice   = 1'b0;
        o_job.rejected = 1'b0;
        o_job.label    = i_req.header_byte[7:4];
        o_job.sig      = sig;
        o_job.last_idx = LAST_SHORT;
        if (long_enough) begin
            unique case (msg)
                MSG_RSP_ACCEPT, MSG_RSP_REJECT: begin
                    n_vld          = 1'b1;
                    o_job.notice   = 1'b1;
                    o_job.rejected = (msg == MSG_RSP_REJECT);
                    o_job.last_idx = 4'd0;
                end
                MSG_GEN_REJECT: n_vld = 1'b0;
                MSG_CMD: begin
                    unique case (sig)
                        SIG_DISCOVER: begin
                            n_vld          = 1'b1;
                            o_job.last_idx = LAST_DISCOVER;
                        end
                        SIG_GET_CAPS: begin
                            n_vld          = 1'b1;
                            o_job.last_idx = LAST_GET_CAPS;
                        end
                        SIG_SET_CONFIG: begin
                            if (i_req.packet_length >= MIN_LEN_SETCFG) begin
                                n_vld    = 1'b1;
                                n_state  = ST_CONFIGURED;
                                n_remote = i_req.first_payload_byte[7:2];
                            end
                        end
                        SIG_OPEN: begin
                            n_vld   = 1'b1;
                            n_state = ST_OPEN;
                        end
                        SIG_START: begin
                            n_vld   = 1'b1;
                            n_state = ST_STREAMING;
                        end
                        SIG_CLOSE: begin
                            n_vld   = 1'b1;
                            n_state = ST_IDLE;
                        end
                        SIG_SUSPEND: begin
                            n_vld   = 1'b1;
                            n_state = ST_OPEN;
                        end
                        SIG_ABORT: begin
                            n_vld   = 1'b1;
                            n_state = ST_IDLE;
                        end
                        default: n_vld = 1'b0;
                    endcase
                end
                default: n_vld = 1'b0;
            endcase
        end
        o_job.stream_state       = n_state;
        o_job.remote_endpoint_id = n_remote;
    end

    assign o_job_vld = i_accept && n_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_remote <= 6'd0;
        end else if (i_accept) begin
            r_state  <= n_state;
            r_remote <= n_remote;
        end
    end

endmodule

`default_nettype wire

### rtl/avdsr_emit.sv
// Reply byte emitter of the AVDTP signalling responder: job register, byte
// sequencer and result register. Depends on avdsr_pkg and the assertion macros.
`default_nettype none
`include "avdtp_signal_responder_core_defines.svh"

module avdsr_emit
    import avdsr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  t_job      i_job,
    input  t_cfg      i_cfg,
    output logic      o_full,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_rsp
);

    logic       r_job_vld;
    t_job       r_job;
    logic [3:0] r_idx;
    logic       r_out_vld;
    t_rsp       r_out;
    logic       out_adv;
    logic       job_last;
    t_rsp       n_out;

    function automatic logic [7:0] f_byte(t_job j, logic [3:0] idx, t_cfg c);
        logic [7:0] b;
        b = 8'h00;
        priority if (j.notice) begin
            b = {2'b00, j.sig};
        end else if (idx == 4'd0) begin
            b = {j.label, HDR_ACCEPT_LOW};
        end else if (idx == 4'd1) begin
            b = {2'b00, j.sig};
        end else if (j.sig == SIG_DISCOVER) begin
            b = (idx == 4'd2) ? {c.local_endpoint_id, 2'b00} : 8'h00;
        end else begin
            unique case (idx)
                4'd2:    b = 8'h01;
                4'd4:    b = 8'h07;
                4'd5:    b = 8'h06;
                4'd8:    b = c.codec_rate_mode_byte;
                4'd9:    b = c.codec_block_subband_byte;
                4'd10:   b = c.min_bitpool;
                4'd11:   b = c.max_bitpool;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    assign out_adv  = !r_out_vld || !i_out_stall;
    assign job_last = (r_idx == r_job.last_idx);
    assign o_full   = r_job_vld && !(out_adv && job_last);

    always_comb begin
        n_out.out_kind           = r_job.notice;
        n_out.out_byte           = f_byte(r_job, r_idx, i_cfg);
        n_out.last_of_run        = job_last;
        n_out.reply_rejected     = r_job.notice && r_job.rejected;
        n_out.stream_state       = r_job.stream_state;
        n_out.remote_endpoint_id = r_job.remote_endpoint_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_idx     <= 4'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_job_vld <= 1'b1;
                r_idx     <= 4'd0;
            end else if (r_job_vld && out_adv) begin
                if (job_last) begin
                    r_job_vld <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
            if (out_adv) begin
                r_out_vld <= r_job_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
        if (out_adv && r_job_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

    `AVDSR_ASSERT(a_idx_in_range, i_clk, i_rst_n, r_job_vld |-> (r_idx <= r_job.last_idx), "Byte index ran past the end of the reply.")
    `AVDSR_ASSERT(a_load_when_free, i_clk, i_rst_n, (i_load && r_job_vld) |-> (out_adv && job_last), "A new job was loaded over one still being emitted.")
    `AVDSR_ASSERT(a_notice_single, i_clk, i_rst_n, (r_out_vld && r_out.out_kind) |-> r_out.last_of_run, "A notice was not the only result of its request.")
    `AVDSR_NEVER(a_reject_on_reply, i_clk, i_rst_n, r_out_vld && r_out.reply_rejected && !r_out.out_kind, "The reject flag was set on a reply byte.")

endmodule

`default_nettype wire

### bench/avdsr_reply_checker.sv
// Checker for the AVDTP signalling responder: watches the request, result and register channels.
// Keeps its own copy of the stream state and registers, predicts every result and compares.
// Depends on avdsr_pkg for the payload types and the signal, message and state codes.
module avdsr_reply_checker
    import avdsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_req       i_in_req,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_rsp       i_out_rsp,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fails,
    output int         o_pending
);

    t_rsp       awaited_replies [$];
    logic [2:0] stream_st;
    logic [5:0] remote_ep;
    logic [5:0] local_ep;
    logic [7:0] rate_mode;
    logic [7:0] block_sub;
    logic [7:0] min_bpool;
    logic [7:0] max_bpool;
    int         fail_count = 0;

    task automatic report(input string field, input int got, input int want);
        $display("result %s: got 0x%0h, expected 0x%0h", field, got, want);
        fail_count++;
    endtask

    task automatic predict_replies(input t_req r);
        logic [3:0] label;
        logic [1:0] msg;
        logic [5:0] sig;
        logic [7:0] reply_bytes [12];
        int         n;
        t_rsp       e;
        label = r.header_byte[7:4];
        msg = r.header_byte[1:0];
        sig = r.signal_byte[5:0];
        if (r.packet_length < MIN_LEN) return;
        if (msg == MSG_RSP_ACCEPT || msg == MSG_RSP_REJECT) begin
            e.out_kind = 1'b1;
            e.out_byte = {2'b00, sig};
            e.last_of_run = 1'b1;
            e.reply_rejected = (msg == MSG_RSP_REJECT);
            e.stream_state = stream_st;
            e.remote_endpoint_id = remote_ep;
            awaited_replies.push_back(e);
            return;
        end
        if (msg != MSG_CMD) return;
        reply_bytes[0] = {label, HDR_ACCEPT_LOW};
        reply_bytes[1] = {2'b00, sig};
        n = 2;
        case (sig)
            SIG_DISCOVER: begin
                reply_bytes[2] = {local_ep, 2'b00};
                reply_bytes[3] = 8'h00;
                n = 4;
            end
            SIG_GET_CAPS: begin
                reply_bytes[2] = 8'h01;
                reply_bytes[3] = 8'h00;
                reply_bytes[4] = 8'h07;
                reply_bytes[5] = 8'h06;
                reply_bytes[6] = 8'h00;
                reply_bytes[7] = 8'h00;
                reply_bytes[8] = rate_mode;
                reply_bytes[9] = block_sub;
                reply_bytes[10] = min_bpool;
                reply_bytes[11] = max_bpool;
                n = 12;
            end
            SIG_SET_CONFIG: begin
                if (r.packet_length < MIN_LEN_SETCFG) return;
                remote_ep = r.first_payload_byte[7:2];
                stream_st = ST_CONFIGURED;
            end
            SIG_OPEN:    stream_st = ST_OPEN;
            SIG_START:   stream_st = ST_STREAMING;
            SIG_CLOSE:   stream_st = ST_IDLE;
            SIG_SUSPEND: stream_st = ST_OPEN;
            SIG_ABORT:   stream_st = ST_IDLE;
            default:     return;
        endcase
        for (int k = 0; k < n; k++) begin
            e.out_kind = 1'b0;
            e.out_byte = reply_bytes[k];
            e.last_of_run = (k == n - 1);
            e.reply_rejected = 1'b0;
            e.stream_state = stream_st;
            e.remote_endpoint_id = remote_ep;
            awaited_replies.push_back(e);
        end
    endtask

    task automatic check_reply(input t_rsp got);
        t_rsp want;
        if (awaited_replies.size() == 0) begin
            report("with nothing awaited", int'(got), 0);
            return;
        end
        want = awaited_replies.pop_front();
        if (got.out_kind !== want.out_kind) report("out_kind", got.out_kind, want.out_kind);
        if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
        if (got.last_of_run !== want.last_of_run)
            report("last_of_run", got.last_of_run, want.last_of_run);
        if (got.reply_rejected !== want.reply_rejected)
            report("reply_rejected", got.reply_rejected, want.reply_rejected);
        if (got.stream_state !== want.stream_state)
            report("stream_state", got.stream_state, want.stream_state);
        if (got.remote_endpoint_id !== want.remote_endpoint_id)
            report("remote_endpoint_id", got.remote_endpoint_id, want.remote_endpoint_id);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_replies.delete();
            stream_st = ST_IDLE;
            remote_ep = '0;
            local_ep = RST_LOCAL_EP;
            rate_mode = RST_RATE_MODE;
            block_sub = RST_BLOCK_SUB;
            min_bpool = RST_MIN_BPOOL;
            max_bpool = RST_MAX_BPOOL;
        end else begin
            if (i_out_valid && !i_out_stall) check_reply(i_out_rsp);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOCAL_EP:  local_ep = i_cfg_data[5:0];
                    CFG_RATE_MODE: rate_mode = i_cfg_data;
                    CFG_BLOCK_SUB: block_sub = i_cfg_data;
                    CFG_MIN_BPOOL: min_bpool = i_cfg_data;
                    CFG_MAX_BPOOL: max_bpool = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_replies(i_in_req);
        end
        o_pending <= awaited_replies.size();
        o_fails <= fail_count;
    end

endmodule

### bench/tb.sv
// Top of the AVDTP signalling responder testbench: clock, reset, requests and register writes.
// Sends directed and random signalling packets in bursts, stalls the results, and gives the verdict.
// Depends on avdsr_pkg, avdtp_signal_responder_core and avdsr_reply_checker.
module tb;
    import avdsr_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 70;
    localparam logic [5:0] KNOWN_SIGS [8] = '{SIG_DISCOVER, SIG_GET_CAPS, SIG_SET_CONFIG,
        SIG_OPEN, SIG_START, SIG_CLOSE, SIG_SUSPEND, SIG_ABORT};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_req       in_req = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_rsp       out_rsp;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    int         fails;
    int         pending;
    int         cycles = 0;
    int         burst_left = 0;
    int         stall_mode = 0;
    int         mode_left = 0;
    int         hold_left = 0;

    always #6 clk = ~clk;

    avdtp_signal_responder_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    avdsr_reply_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("avdtp_signal_responder_core: mismatch");
            $finish;
        end
    end

    // The result side switches between no stalls, scattered stalls and long stall runs.
    always @(posedge clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: begin
                if (hold_left == 0) begin
                    out_stall <= ~out_stall;
                    hold_left <= $urandom_range(1, 8);
                end else begin
                    hold_left <= hold_left - 1;
                end
            end
        endcase
    end

    function automatic t_req pkt(input logic [7:0] hdr, input logic [7:0] sig,
                                 input logic [7:0] pay, input logic [15:0] len);
        t_req r;
        r.header_byte = hdr;
        r.signal_byte = sig;
        r.first_payload_byte = pay;
        r.packet_length = len;
        return r;
    endfunction

    function automatic t_req good_packet();
        t_req r;
        r.header_byte = 8'($urandom);
        r.signal_byte = {2'($urandom), KNOWN_SIGS[$urandom_range(0, 7)]};
        r.first_payload_byte = 8'($urandom);
        r.packet_length = 16'($urandom_range(4, 64));
        if ($urandom_range(0, 9) == 0) r.packet_length = 16'($urandom_range(4, 65535));
        case ($urandom_range(0, 9))
            0: r.header_byte[1:0] = MSG_RSP_ACCEPT;
            1: begin
                r.header_byte[1:0] = MSG_RSP_REJECT;
                r.signal_byte = 8'($urandom);
            end
            default: r.header_byte[1:0] = MSG_CMD;
        endcase
        return r;
    endfunction

    function automatic t_req noise_packet();
        t_req r;
        r = good_packet();
        case ($urandom_range(0, 3))
            0: r.packet_length = 16'($urandom_range(0, 1));
            1: r.header_byte[1:0] = MSG_GEN_REJECT;
            2: begin
                r.header_byte[1:0] = MSG_CMD;
                case ($urandom_range(0, 3))
                    0: r.signal_byte[5:0] = 6'h00;
                    1: r.signal_byte[5:0] = 6'h04;
                    2: r.signal_byte[5:0] = 6'h05;
                    default: r.signal_byte[5:0] = 6'($urandom_range(11, 63));
                endcase
            end
            default: begin
                r.header_byte[1:0] = MSG_CMD;
                r.signal_byte[5:0] = SIG_SET_CONFIG;
                r.packet_length = 16'($urandom_range(2, 3));
            end
        endcase
        return r;
    endfunction

    task automatic send(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input t_cfg c);
        logic [7:0] vals [5];
        vals = '{{2'b00, c.local_endpoint_id}, c.codec_rate_mode_byte,
                 c.codec_block_subband_byte, c.min_bitpool, c.max_bitpool};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        t_cfg c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send(pkt(8'hF0, 8'h01, 8'h00, 16'd2));
        send(pkt(8'h00, 8'h02, 8'hFF, 16'hFFFF));
        send(pkt(8'h10, 8'h03, 8'hFC, 16'd3));
        send(pkt(8'h2C, 8'hC3, 8'hFF, 16'd4));
        send(pkt(8'h30, 8'h06, 8'h00, 16'd4));
        send(pkt(8'h44, 8'h07, 8'h00, 16'd4));
        send(pkt(8'h58, 8'h09, 8'h00, 16'd4));
        send(pkt(8'h60, 8'h08, 8'h00, 16'd4));
        send(pkt(8'h70, 8'h03, 8'h00, 16'd4));
        send(pkt(8'h80, 8'h46, 8'h00, 16'd2));
        send(pkt(8'h90, 8'h0A, 8'h00, 16'd2));
        send(pkt(8'hF2, 8'hFF, 8'hFF, 16'd2));
        send(pkt(8'h03, 8'h00, 8'h00, 16'd2));
        send(pkt(8'h41, 8'h01, 8'h00, 16'd10));
        send(pkt(8'hA0, 8'h04, 8'h00, 16'd8));
        send(pkt(8'hB0, 8'h05, 8'h00, 16'd8));
        send(pkt(8'hC0, 8'h3F, 8'h00, 16'd8));
        send(pkt(8'hD0, 8'h00, 8'h00, 16'd8));
        send(pkt(8'hE0, 8'h01, 8'h00, 16'd0));
        send(pkt(8'hE0, 8'h02, 8'h00, 16'd1));
        send(pkt(8'h02, 8'h01, 8'h00, 16'd1));
        send(pkt(8'h5C, 8'h81, 8'h00, 16'h8000));

        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case (phase)
                0: c = '{6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
                1: c = '{6'd1, 8'h00, 8'h00, 8'h00, 8'h00};
                default: c = '{6'($urandom_range(1, 63)), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom)};
            endcase
            write_regs(c);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 7) == 0) send(noise_packet());
                send(good_packet());
            end
        end
        drain();

        if (fails == 0)
            $display("avdtp_signal_responder_core: match");
        else
            $display("avdtp_signal_responder_core: mismatch");
        $finish;
    end

endmodule

### avdtp_signal_responder_core.f
+incdir+rtl
rtl/avdsr_pkg.sv
rtl/avdsr_cfg.sv
rtl/avdsr_decode.sv
rtl/avdsr_emit.sv
rtl/avdtp_signal_responder_core.sv
bench/avdsr_reply_checker.sv
bench/tb.sv
